// ===== design/assert_macros.svh =====
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PMA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PMA_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define PMA_ASSERT(lbl, clk, rst_n, prop)
`define PMA_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== design/pma_pkg.sv =====
// types, constants and helpers for the particle moment accumulator
package pma_pkg;

    localparam int unsigned NUM_POPS = 4;
    localparam int unsigned FIFO_DEPTH = 2;

    localparam logic [2:0] CFG_MASK   = 3'd0;
    localparam logic [2:0] CFG_MASS   = 3'd1;
    localparam logic [2:0] CFG_CHARGE = 3'd2;
    localparam logic [2:0] CFG_REF_X  = 3'd3;
    localparam logic [2:0] CFG_REF_Y  = 3'd4;
    localparam logic [2:0] CFG_REF_Z  = 3'd5;

    localparam logic [47:0] W48_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [2:0]  LAST_DIV = 3'd6;

    typedef struct packed {
        logic               present;
        logic [23:0]        weight;
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [23:0] vel_z;
        logic [1:0]         population;
        logic               last;
    } t_pma_in;

    typedef struct packed {
        logic [47:0]        weight_sum;
        logic [63:0]        mass_sum;
        logic signed [63:0] charge_sum;
        logic signed [23:0] avg_vel_x;
        logic signed [23:0] avg_vel_y;
        logic signed [23:0] avg_vel_z;
        logic signed [23:0] bulk_vel_x;
        logic signed [23:0] bulk_vel_y;
        logic signed [23:0] bulk_vel_z;
        logic [47:0]        mean_energy;
        logic               empty_set;
    } t_pma_out;

    // classified particle handed from front to back
    typedef struct packed {
        logic               sel;
        logic               last;
        logic [23:0]        w;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] vz;
        logic [15:0]        m;
        logic signed [15:0] q;
    } t_pma_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_ENG,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } t_pma_state;

    function automatic logic signed [63:0] sat_add_s(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add_s = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add_s = s[63:0];
        end
    endfunction

    function automatic logic [63:0] sat_add_u64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add_u64 = s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

// ===== design/pma_front.sv =====
// front end: classifies requests and queues them for the back end
`include "assert_macros.svh"
module pma_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pma_pkg::t_pma_in   i_in_data,
    input  logic [3:0]         i_mask,
    input  logic [63:0]        i_mass_tab,
    input  logic [63:0]        i_chg_tab,
    output logic               o_item_valid,
    output pma_pkg::t_pma_item o_item,
    input  logic               i_item_pop
);
    import pma_pkg::*;

    t_pma_item  w_item;
    t_pma_item  r_q [FIFO_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_in_range;
    logic       w_push;

    always_comb begin
        w_in_range = {1'b0, i_in_data.population} < 3'(NUM_POPS);
        w_item.sel = i_in_data.present & w_in_range
                   & ((i_mask == 4'd0) | i_mask[i_in_data.population]);
        w_item.last = i_in_data.last;
        w_item.w    = i_in_data.weight;
        w_item.vx   = i_in_data.vel_x;
        w_item.vy   = i_in_data.vel_y;
        w_item.vz   = i_in_data.vel_z;
        w_item.m    = i_mass_tab[{i_in_data.population, 4'd0} +: 16];
        w_item.q    = i_chg_tab[{i_in_data.population, 4'd0} +: 16];
    end

    assign o_in_ready   = r_cnt != 2'(FIFO_DEPTH);
    assign w_push       = i_in_valid & o_in_ready;
    assign o_item_valid = r_cnt != 2'd0;
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_item_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_item_pop);
        end
    end

    `PMA_NEVER(a_fifo_overflow, i_clk, i_rst_n, r_cnt > 2'(FIFO_DEPTH))
    `PMA_NEVER(a_pop_empty, i_clk, i_rst_n, i_item_pop && r_cnt == 2'd0)
    `PMA_ASSERT(a_cnt_track, i_clk, i_rst_n,
        (w_push && !i_item_pop) |=> r_cnt == $past(r_cnt) + 2'd1)

endmodule

// ===== design/pma_div.sv =====
// shared restoring divider, one quotient bit per cycle
`include "assert_macros.svh"
module pma_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [63:0] r_rem;
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [63:0] r_quo;
    logic [6:0]  r_cnt;
    logic        r_done;
    logic [64:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_num[63]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign o_busy  = r_cnt != 7'd0;
    assign o_done  = r_done;
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 64'd0;
            r_num <= i_num;
            r_den <= i_den;
            r_quo <= 64'd0;
        end else if (o_busy) begin
            r_rem <= w_ge ? 64'(w_trial - {1'b0, r_den}) : w_trial[63:0];
            r_num <= {r_num[62:0], 1'b0};
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 7'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_cnt == 7'd1;
            if (i_start) begin
                r_cnt <= 7'd64;
            end else if (o_busy) begin
                r_cnt <= r_cnt - 7'd1;
            end
        end
    end

    `PMA_NEVER(a_start_busy, i_clk, i_rst_n, i_start && o_busy)
    `PMA_ASSERT(a_done_after, i_clk, i_rst_n, o_done |-> $past(r_cnt) == 7'd1)
    `PMA_NEVER(a_done_busy, i_clk, i_rst_n, o_done && o_busy)

endmodule

// ===== design/pma_back.sv =====
// back end: products, saturating sums, end-of-set divisions and result register
`include "assert_macros.svh"
module pma_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    input  pma_pkg::t_pma_item i_item,
    output logic               o_item_pop,
    input  logic signed [23:0] i_ref_x,
    input  logic signed [23:0] i_ref_y,
    input  logic signed [23:0] i_ref_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pma_pkg::t_pma_out  o_out_data
);
    import pma_pkg::*;

    t_pma_state r_state;
    t_pma_state n_state;
    t_pma_item  r_it;

    logic [39:0]        r_wm;
    logic signed [40:0] r_wq;
    logic signed [47:0] r_wv [3];
    logic [48:0]        r_d2 [3];
    logic signed [63:0] r_wmv [3];
    logic [49:0]        r_s;
    logic [64:0]        r_plo;
    logic [64:0]        r_phi;
    logic [63:0]        r_e;

    logic [47:0]        r_acc_w;
    logic [63:0]        r_acc_m;
    logic signed [63:0] r_acc_q;
    logic signed [63:0] r_acc_mw [3];
    logic signed [63:0] r_acc_mm [3];
    logic [63:0]        r_acc_e;

    logic [2:0]         r_k;
    logic signed [23:0] r_vres [6];
    logic [47:0]        r_me;
    logic               r_out_valid;
    t_pma_out           r_out;

    logic signed [23:0] w_v [3];
    logic signed [23:0] w_r [3];
    logic signed [24:0] w_dif [3];
    logic [24:0]        w_d [3];
    logic [90:0]        w_tot;
    logic signed [63:0] w_num;
    logic [63:0]        w_den;
    logic               w_neg;
    logic [63:0]        w_mag;
    logic               w_div_start;
    logic               w_div_busy;
    logic               w_div_done;
    logic [63:0]        w_quo;
    logic [47:0]        w_res;
    logic               w_load;

    pma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_mag),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        w_v[0] = r_it.vx;
        w_v[1] = r_it.vy;
        w_v[2] = r_it.vz;
        w_r[0] = i_ref_x;
        w_r[1] = i_ref_y;
        w_r[2] = i_ref_z;
        for (int i = 0; i < 3; i++) begin
            w_dif[i] = {w_v[i][23], w_v[i]} - {w_r[i][23], w_r[i]};
            w_d[i]   = w_dif[i][24] ? 25'(-w_dif[i]) : 25'(w_dif[i]);
        end
        w_tot = {r_phi, 25'd0} + {26'd0, r_plo};
    end

    // operand select for the k-th end-of-set division
    always_comb begin
        unique case (r_k)
            3'd0: w_num = r_acc_mw[0];
            3'd1: w_num = r_acc_mw[1];
            3'd2: w_num = r_acc_mw[2];
            3'd3: w_num = r_acc_mm[0];
            3'd4: w_num = r_acc_mm[1];
            3'd5: w_num = r_acc_mm[2];
            default: w_num = r_acc_e;
        endcase
        w_den = (r_k == 3'd3 || r_k == 3'd4 || r_k == 3'd5) ? r_acc_m : {16'd0, r_acc_w};
        w_neg = (r_k != LAST_DIV) && w_num[63];
        w_mag = w_neg ? 64'(-w_num) : w_num;
        if (r_k == LAST_DIV) begin
            w_res = (w_quo > {16'd0, W48_MAX}) ? W48_MAX : w_quo[47:0];
        end else if (w_neg) begin
            w_res = {24'd0, (w_quo > 64'h80_0000) ? 24'h80_0000 : 24'(-w_quo)};
        end else begin
            w_res = {24'd0, (w_quo > 64'h7F_FFFF) ? 24'h7F_FFFF : w_quo[23:0]};
        end
    end

    always_comb begin
        n_state     = r_state;
        o_item_pop  = 1'b0;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    if (i_item.sel) begin
                        n_state = ST_MUL1;
                    end else if (i_item.last) begin
                        n_state = ST_DIV_START;
                    end
                end
            end
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_MUL3;
            ST_MUL3: n_state = ST_ENG;
            ST_ENG:  n_state = ST_ACC;
            ST_ACC:  n_state = r_it.last ? ST_DIV_START : ST_IDLE;
            ST_DIV_START: begin
                if (w_den == 64'd0) begin
                    n_state = (r_k == LAST_DIV) ? ST_OUT : ST_DIV_START;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_k == LAST_DIV) ? ST_OUT : ST_DIV_START;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // product pipeline registers
    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_it <= i_item;
        end
        if (r_state == ST_MUL1) begin
            r_wm <= {16'd0, r_it.w} * {24'd0, r_it.m};
            r_wq <= $signed({17'd0, r_it.w}) * $signed({{25{r_it.q[15]}}, r_it.q});
            for (int i = 0; i < 3; i++) begin
                r_wv[i] <= $signed({24'd0, r_it.w}) * $signed({{24{w_v[i][23]}}, w_v[i]});
                r_d2[i] <= {24'd0, w_d[i]} * {24'd0, w_d[i]};
            end
        end
        if (r_state == ST_MUL2) begin
            for (int i = 0; i < 3; i++) begin
                r_wmv[i] <= $signed({24'd0, r_wm}) * $signed({{40{w_v[i][23]}}, w_v[i]});
            end
            r_s <= 50'(r_d2[0]) + 50'(r_d2[1]) + 50'(r_d2[2]);
        end
        if (r_state == ST_MUL3) begin
            r_plo <= {25'd0, r_wm} * {40'd0, r_s[24:0]};
            r_phi <= {25'd0, r_wm} * {40'd0, r_s[49:25]};
        end
        if (r_state == ST_ENG) begin
            r_e <= (w_tot[90:64] != 27'd0) ? {64{1'b1}} : w_tot[63:0];
        end
    end

    // division results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= 3'd0;
        end else if ((r_state == ST_DIV_START && w_den == 64'd0)
                     || (r_state == ST_DIV_WAIT && w_div_done)) begin
            r_k <= (r_k == LAST_DIV) ? 3'd0 : r_k + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV_START && w_den == 64'd0) begin
            if (r_k == LAST_DIV) begin
                r_me <= 48'd0;
            end else begin
                r_vres[r_k] <= 24'd0;
            end
        end else if (r_state == ST_DIV_WAIT && w_div_done) begin
            if (r_k == LAST_DIV) begin
                r_me <= w_res;
            end else begin
                r_vres[r_k] <= w_res[23:0];
            end
        end
    end

    // running sums, cleared when a result is handed over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_load) begin
            r_acc_w <= 48'd0;
            r_acc_m <= 64'd0;
            r_acc_q <= 64'sd0;
            r_acc_e <= 64'd0;
            for (int i = 0; i < 3; i++) begin
                r_acc_mw[i] <= 64'sd0;
                r_acc_mm[i] <= 64'sd0;
            end
        end else if (r_state == ST_ACC) begin
            r_acc_w <= ({1'b0, r_acc_w} + {25'd0, r_it.w} > {1'b0, W48_MAX})
                       ? W48_MAX : 48'(r_acc_w + {24'd0, r_it.w});
            r_acc_m <= sat_add_u64(r_acc_m, {24'd0, r_wm});
            r_acc_q <= sat_add_s(r_acc_q, {{23{r_wq[40]}}, r_wq});
            r_acc_e <= sat_add_u64(r_acc_e, r_e);
            for (int i = 0; i < 3; i++) begin
                r_acc_mw[i] <= sat_add_s(r_acc_mw[i], {{16{r_wv[i][47]}}, r_wv[i]});
                r_acc_mm[i] <= sat_add_s(r_acc_mm[i], r_wmv[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.weight_sum  <= r_acc_w;
            r_out.mass_sum    <= r_acc_m;
            r_out.charge_sum  <= r_acc_q;
            r_out.avg_vel_x   <= r_vres[0];
            r_out.avg_vel_y   <= r_vres[1];
            r_out.avg_vel_z   <= r_vres[2];
            r_out.bulk_vel_x  <= r_vres[3];
            r_out.bulk_vel_y  <= r_vres[4];
            r_out.bulk_vel_z  <= r_vres[5];
            r_out.mean_energy <= r_me;
            r_out.empty_set   <= r_acc_w == 48'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PMA_ASSERT(a_load_valid, i_clk, i_rst_n, w_load |=> r_out_valid)
    `PMA_ASSERT(a_load_clears, i_clk, i_rst_n, w_load |=> r_acc_w == 48'd0)
    `PMA_NEVER(a_idle_div, i_clk, i_rst_n, r_state == ST_IDLE && w_div_busy)

endmodule

// ===== design/particle_moment_accumulator.sv =====
// selected particles pass states MUL1, MUL2, MUL3, ENG and ACC; skipped ones are popped in IDLE
// end of set: 7 divisions in turn in the shared divider
// a two-entry request queue lets the front accept while the back works
// reset clears configuration, sums, queue and result valid flag; no clearing pass
// top level: configuration registers, front end and back end
module particle_moment_accumulator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pma_pkg::t_pma_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pma_pkg::t_pma_out o_out_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_data
);
    import pma_pkg::*;

    logic [3:0]         r_mask;
    logic [63:0]        r_mass;
    logic [63:0]        r_chg;
    logic signed [23:0] r_ref_x;
    logic signed [23:0] r_ref_y;
    logic signed [23:0] r_ref_z;
    logic               w_item_valid;
    logic               w_item_pop;
    t_pma_item          w_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= 4'd0;
            r_mass  <= 64'd0;
            r_chg   <= 64'd0;
            r_ref_x <= 24'sd0;
            r_ref_y <= 24'sd0;
            r_ref_z <= 24'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MASK:   r_mask  <= i_cfg_data[3:0];
                CFG_MASS:   r_mass  <= i_cfg_data;
                CFG_CHARGE: r_chg   <= i_cfg_data;
                CFG_REF_X:  r_ref_x <= i_cfg_data[23:0];
                CFG_REF_Y:  r_ref_y <= i_cfg_data[23:0];
                CFG_REF_Z:  r_ref_z <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    pma_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_mask       (r_mask),
        .i_mass_tab   (r_mass),
        .i_chg_tab    (r_chg),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_pop   (w_item_pop)
    );

    pma_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .i_ref_x      (r_ref_x),
        .i_ref_y      (r_ref_y),
        .i_ref_z      (r_ref_z),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule
